### hw/rtl/ax25_frame_header_check_unit_macros.svh
// Assertion macros for the AX.25 frame header check unit
`ifndef AX25_FRAME_HEADER_CHECK_UNIT_MACROS_SVH
`define AX25_FRAME_HEADER_CHECK_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define AX25FHC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ax25fhc: same-cycle check failed");

`define AX25FHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ax25fhc: next-cycle check failed");

`else

`define AX25FHC_ASSERT_SAME(lbl, ante, cons)

`define AX25FHC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### hw/rtl/ax25fhc_pkg.sv
// Shared types, constants and the CRC byte step of the frame header check
package ax25fhc_pkg;

  localparam int unsigned MaxAddrFieldsDef = 10;
  localparam int unsigned FcW = 5;
  localparam int unsigned CntW = 9;
  localparam int unsigned QueueDepth = 2;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [CntW-1:0] CntMax = 9'd511;
  localparam logic [CntW-1:0] MinFrameLen = 9'd14;
  localparam logic [CntW-1:0] SsidPos = 9'd13;
  localparam logic [7:0] MaxFrameLenRst = 8'd255;

  localparam logic [1:0] CFG_CHECK_FCS = 2'd0;
  localparam logic [1:0] CFG_MAX_FRAME_LEN = 2'd1;

  typedef struct packed {
    logic       valid;
    logic [1:0] index;
    logic [7:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [CntW-1:0] len;
    logic [FcW-1:0]  fields;
    logic            fcs_ok;
    logic            ext;
    logic [7:0]      used;
    logic            cseen;
    logic [7:0]      ctrl;
    logic [3:0]      ssid;
  } frame_sum_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/ax25fhc_front.sv
// Byte front end: CRC, trailer delay, address field scan and frame summary
module ax25fhc_front import ax25fhc_pkg::*; #(
  parameter int unsigned MAX_ADDR_FIELDS = MaxAddrFieldsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       sum_valid_o,
  input  logic       sum_ready_i,
  output frame_sum_t sum_o
);

  localparam logic [FcW-1:0] MaxFields = FcW'(MAX_ADDR_FIELDS);

  logic [15:0]     crc_q, crc_d;
  logic [7:0]      dly0_q, dly1_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [FcW-1:0]  fc_q, fc_d, fc_inc, fc_rep;
  logic            scan_q, scan_d, ext_q, ext_d;
  logic [7:0]      used_q, used_d;
  logic [3:0]      ssid_q, ssid_d;
  logic [7:0]      ctrl_q, ctrl_d;
  logic            cseen_q, cseen_d;
  logic [CntW-1:0] fc_ext, base;
  logic            field_end, accept;

  assign in_ready_o = sum_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  assign fc_ext = {{(CntW-FcW){1'b0}}, fc_q};
  assign base   = (fc_ext << 3) - fc_ext;
  assign fc_inc = fc_q + FcW'(1);
  assign fc_rep = fc_q - FcW'(2);

  always_comb begin
    crc_d   = (cnt_q >= CntW'(2)) ? crc_byte(crc_q, dly0_q) : crc_q;
    cnt_d   = (cnt_q < CntMax) ? cnt_q + CntW'(1) : cnt_q;
    ssid_d  = (cnt_q == SsidPos) ? data_byte_i[4:1] : ssid_q;
    ctrl_d  = ctrl_q;
    cseen_d = cseen_q;
    fc_d    = fc_q;
    scan_d  = scan_q;
    ext_d   = ext_q;
    used_d  = used_q;
    if (cnt_q == base) begin
      ctrl_d  = data_byte_i;
      cseen_d = 1'b1;
    end
    field_end = !scan_q && (fc_q < MaxFields) && (cnt_q == base + CntW'(6));
    if (field_end) begin
      if ((fc_q >= FcW'(2)) && (fc_rep < FcW'(8)) && data_byte_i[7]) begin
        used_d[fc_rep[2:0]] = 1'b1;
      end
      fc_d    = fc_inc;
      cseen_d = 1'b0;
      if (data_byte_i[0]) begin
        ext_d  = 1'b1;
        scan_d = 1'b1;
      end
      if (fc_inc >= MaxFields) begin
        scan_d = 1'b1;
      end
    end
  end

  always_comb begin
    sum_o.len    = cnt_d;
    sum_o.fields = fc_d;
    sum_o.fcs_ok = (cnt_d >= CntW'(2)) && (crc_d == {data_byte_i, dly1_q});
    sum_o.ext    = ext_d;
    sum_o.used   = used_d;
    sum_o.cseen  = cseen_d;
    sum_o.ctrl   = ctrl_d;
    sum_o.ssid   = ssid_d;
  end

  assign sum_valid_o = in_valid_i & last_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CrcInit;
      dly0_q  <= '0;
      dly1_q  <= '0;
      cnt_q   <= '0;
      fc_q    <= '0;
      scan_q  <= 1'b0;
      ext_q   <= 1'b0;
      used_q  <= '0;
      ssid_q  <= '0;
      ctrl_q  <= '0;
      cseen_q <= 1'b0;
    end else if (accept) begin
      if (last_byte_i) begin
        crc_q   <= CrcInit;
        dly0_q  <= '0;
        dly1_q  <= '0;
        cnt_q   <= '0;
        fc_q    <= '0;
        scan_q  <= 1'b0;
        ext_q   <= 1'b0;
        used_q  <= '0;
        ssid_q  <= '0;
        ctrl_q  <= '0;
        cseen_q <= 1'b0;
      end else begin
        crc_q   <= crc_d;
        dly0_q  <= dly1_q;
        dly1_q  <= data_byte_i;
        cnt_q   <= cnt_d;
        fc_q    <= fc_d;
        scan_q  <= scan_d;
        ext_q   <= ext_d;
        used_q  <= used_d;
        ssid_q  <= ssid_d;
        ctrl_q  <= ctrl_d;
        cseen_q <= cseen_d;
      end
    end
  end

endmodule

### hw/rtl/ax25fhc_queue.sv
// Short summary queue between front end and result stage
module ax25fhc_queue import ax25fhc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_valid_i,
  output logic       wr_ready_o,
  input  frame_sum_t wr_data_i,
  output logic       rd_valid_o,
  input  logic       rd_ready_i,
  output frame_sum_t rd_data_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntQW = $clog2(QueueDepth + 1);

  frame_sum_t              mem_q [QueueDepth];
  logic [PtrW-1:0]         wptr_q, rptr_q;
  logic [CntQW-1:0]        cnt_q;
  logic                    push, pop;

  assign wr_ready_o = (cnt_q < CntQW'(QueueDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign push       = wr_valid_i & wr_ready_o;
  assign pop        = rd_valid_o & rd_ready_i;
  assign rd_data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop) begin
        rptr_q <= (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + CntQW'(1);
        2'b01:   cnt_q <= cnt_q - CntQW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### hw/rtl/ax25fhc_back.sv
// Result stage: configuration registers, header decode and output register
module ax25fhc_back import ax25fhc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_wr_t    cfg_i,
  input  logic       sum_valid_i,
  output logic       sum_ready_o,
  input  frame_sum_t sum_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       valid_frame_o,
  output logic       fcs_ok_o,
  output logic       addr_ok_o,
  output logic [3:0] addr_fields_o,
  output logic [3:0] digi_count_o,
  output logic [7:0] digi_used_mask_o,
  output logic       has_free_digi_o,
  output logic [2:0] free_digi_o,
  output logic       has_control_o,
  output logic [7:0] control_byte_o,
  output logic [6:0] hdr_bytes_o,
  output logic [3:0] sender_ssid_o
);

  logic            check_fcs_q;
  logic [7:0]      max_len_q;
  logic            out_valid_q;
  logic            valid_d, addr_ok_d, has_next_d, has_ctrl_d;
  logic [2:0]      next_d;
  logic [FcW-1:0]  digis;
  logic [CntW-1:0] f_ext, hdr_base, hdr_d;
  logic [7:0]      cand;
  logic            load;

  logic            valid_q, fcs_q, addr_ok_q, has_next_q, has_ctrl_q;
  logic [3:0]      fields_q, digis_q, ssid_q;
  logic [7:0]      mask_q, ctrl_q;
  logic [2:0]      next_q;
  logic [6:0]      hdr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_fcs_q <= 1'b1;
      max_len_q   <= MaxFrameLenRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_CHECK_FCS:     check_fcs_q <= cfg_i.data[0];
        CFG_MAX_FRAME_LEN: max_len_q   <= cfg_i.data;
        default:           ;
      endcase
    end
  end

  assign digis    = sum_i.fields - FcW'(2);
  assign f_ext    = {{(CntW-FcW){1'b0}}, sum_i.fields};
  assign hdr_base = (f_ext << 3) - f_ext;

  always_comb begin
    addr_ok_d = (sum_i.len >= MinFrameLen) && (sum_i.fields >= FcW'(2));
    valid_d   = addr_ok_d && (sum_i.len <= {1'b0, max_len_q}) &&
                (!check_fcs_q || sum_i.fcs_ok) && sum_i.ext;
    for (int i = 0; i < 8; i++) begin
      cand[i] = (FcW'(i) < digis) && !sum_i.used[i];
    end
    has_next_d = |cand;
    next_d     = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (cand[i]) begin
        next_d = 3'(i);
      end
    end
    has_ctrl_d = (sum_i.len >= hdr_base + CntW'(1)) && sum_i.cseen;
    hdr_d      = hdr_base;
    if (has_ctrl_d) begin
      hdr_d = (sum_i.len >= hdr_base + CntW'(2)) ? hdr_base + CntW'(2)
                                                 : hdr_base + CntW'(1);
    end
  end

  assign load        = sum_valid_i && (!out_valid_q || out_ready_i);
  assign sum_ready_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sum_ready_o) begin
      out_valid_q <= sum_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      valid_q    <= valid_d;
      fcs_q      <= sum_i.fcs_ok;
      addr_ok_q  <= addr_ok_d;
      fields_q   <= addr_ok_d ? sum_i.fields[3:0] : 4'd0;
      digis_q    <= addr_ok_d ? digis[3:0] : 4'd0;
      mask_q     <= addr_ok_d ? sum_i.used : 8'd0;
      has_next_q <= addr_ok_d && has_next_d;
      next_q     <= addr_ok_d ? next_d : 3'd0;
      has_ctrl_q <= addr_ok_d && has_ctrl_d;
      ctrl_q     <= (addr_ok_d && has_ctrl_d) ? sum_i.ctrl : 8'd0;
      hdr_q      <= addr_ok_d ? hdr_d[6:0] : 7'd0;
      ssid_q     <= addr_ok_d ? sum_i.ssid : 4'd0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign valid_frame_o    = valid_q;
  assign fcs_ok_o         = fcs_q;
  assign addr_ok_o        = addr_ok_q;
  assign addr_fields_o    = fields_q;
  assign digi_count_o     = digis_q;
  assign digi_used_mask_o = mask_q;
  assign has_free_digi_o  = has_next_q;
  assign free_digi_o      = next_q;
  assign has_control_o    = has_ctrl_q;
  assign control_byte_o   = ctrl_q;
  assign hdr_bytes_o      = hdr_q;
  assign sender_ssid_o    = ssid_q;

endmodule

### hw/rtl/ax25_frame_header_check_unit.sv
// Top level of the AX.25 frame header check unit
//
//   channel  direction  handshake                 transfer carries
//   in       input      in_valid_i / in_ready_o   data_byte_i, last_byte_i
//   out      output     out_valid_o / out_ready_i frame summary fields
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One byte per cycle unless the queue is full; CRC and field scan run per byte.
// A summary enters the queue with the final byte, then the output register.
// Reset clears frame state and loads check_fcs = 1, max_frame_len = 255.
// Bytes stall only while the two-entry summary queue is full.
module ax25_frame_header_check_unit import ax25fhc_pkg::*; #(
  parameter int unsigned MAX_ADDR_FIELDS = MaxAddrFieldsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       valid_frame_o,
  output logic       fcs_ok_o,
  output logic       addr_ok_o,
  output logic [3:0] addr_fields_o,
  output logic [3:0] digi_count_o,
  output logic [7:0] digi_used_mask_o,
  output logic       has_free_digi_o,
  output logic [2:0] free_digi_o,
  output logic       has_control_o,
  output logic [7:0] control_byte_o,
  output logic [6:0] hdr_bytes_o,
  output logic [3:0] sender_ssid_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

`include "ax25_frame_header_check_unit_macros.svh"

  frame_sum_t fe_sum, q_sum;
  logic       fe_valid, q_wr_ready, q_valid, be_ready;
  cfg_wr_t    cfg_wr;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  ax25fhc_front #(
    .MAX_ADDR_FIELDS(MAX_ADDR_FIELDS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .sum_valid_o(fe_valid),
    .sum_ready_i(q_wr_ready),
    .sum_o      (fe_sum)
  );

  ax25fhc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(fe_valid),
    .wr_ready_o(q_wr_ready),
    .wr_data_i (fe_sum),
    .rd_valid_o(q_valid),
    .rd_ready_i(be_ready),
    .rd_data_o (q_sum)
  );

  ax25fhc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_wr),
    .sum_valid_i     (q_valid),
    .sum_ready_o     (be_ready),
    .sum_i           (q_sum),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .valid_frame_o   (valid_frame_o),
    .fcs_ok_o        (fcs_ok_o),
    .addr_ok_o       (addr_ok_o),
    .addr_fields_o   (addr_fields_o),
    .digi_count_o    (digi_count_o),
    .digi_used_mask_o(digi_used_mask_o),
    .has_free_digi_o (has_free_digi_o),
    .free_digi_o     (free_digi_o),
    .has_control_o   (has_control_o),
    .control_byte_o  (control_byte_o),
    .hdr_bytes_o     (hdr_bytes_o),
    .sender_ssid_o   (sender_ssid_o)
  );

  `AX25FHC_ASSERT_SAME(a_valid_needs_addr, out_valid_o && valid_frame_o, addr_ok_o)
  `AX25FHC_ASSERT_SAME(a_no_addr_zero, out_valid_o && !addr_ok_o, !(|{hdr_bytes_o, addr_fields_o}))
  `AX25FHC_ASSERT_SAME(a_free_ok, out_valid_o && has_free_digi_o, !digi_used_mask_o[free_digi_o])
  `AX25FHC_ASSERT_NEXT(a_last_queued, in_valid_i && in_ready_o && last_byte_i, q_valid || out_valid_o)

endmodule

### test/ax25_frame_header_check_unit_test.sv
// Self-checking regression bench for the AX.25 frame header check unit
`timescale 1ns / 100ps

module ax25_frame_header_check_unit_test;
  import ax25fhc_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned FieldLimit = MaxAddrFieldsDef;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned HoldOffAfter = 1000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  typedef struct packed {
    logic       valid_frame;
    logic       fcs_ok;
    logic       addr_ok;
    logic [3:0] addr_fields;
    logic [3:0] digi_count;
    logic [7:0] digi_used_mask;
    logic       has_free_digi;
    logic [2:0] free_digi;
    logic       has_control;
    logic [7:0] control_byte;
    logic [6:0] hdr_bytes;
    logic [3:0] sender_ssid;
  } summary_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_CHECK_FCS;
  logic [7:0] cfg_data = 8'h00;

  logic       valid_frame;
  logic       fcs_ok;
  logic       addr_ok;
  logic [3:0] addr_fields;
  logic [3:0] digi_count;
  logic [7:0] digi_used_mask;
  logic       has_free_digi;
  logic [2:0] free_digi;
  logic       has_control;
  logic [7:0] control_byte;
  logic [6:0] hdr_bytes;
  logic [3:0] sender_ssid;

  frame_byte_t pending_bytes[$];
  summary_t    expected_summaries[$];
  logic [7:0]  frame_buf[$];

  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned hold_left = 0;
  logic        hold_given = 1'b0;

  // predictor state and its copy of the registers
  logic        fcs_required = 1'b1;
  logic [7:0]  len_limit = MaxFrameLenRst;
  logic [15:0] run_crc = 16'hFFFF;
  logic [7:0]  held [2] = '{8'h00, 8'h00};
  logic [8:0]  nbytes = '0;
  int unsigned fld = 0;
  logic        done_scan = 1'b0;
  logic        ext_seen = 1'b0;
  logic [7:0]  h_bits = '0;
  logic [3:0]  ssid = '0;
  logic [7:0]  ctrl = '0;
  logic        ctrl_valid = 1'b0;

  ax25_frame_header_check_unit i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .data_byte_i      (data_byte),
    .last_byte_i      (last_byte),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .valid_frame_o    (valid_frame),
    .fcs_ok_o         (fcs_ok),
    .addr_ok_o        (addr_ok),
    .addr_fields_o    (addr_fields),
    .digi_count_o     (digi_count),
    .digi_used_mask_o (digi_used_mask),
    .has_free_digi_o  (has_free_digi),
    .free_digi_o      (free_digi),
    .has_control_o    (has_control),
    .control_byte_o   (control_byte),
    .hdr_bytes_o      (hdr_bytes),
    .sender_ssid_o    (sender_ssid),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = crc[15] ^ b[i];
      crc = {crc[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
    end
    return crc;
  endfunction

  function automatic logic idle_now();
    if (cycle_count >= 200 && cycle_count < 700) begin
      return 1'b0;
    end
    return $urandom_range(99) < 6;
  endfunction

  function automatic void check_field(string label, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
    end
  endfunction

  task automatic clear_frame_state();
    run_crc = 16'hFFFF;
    held[0] = 8'h00;
    held[1] = 8'h00;
    nbytes = '0;
    fld = 0;
    done_scan = 1'b0;
    ext_seen = 1'b0;
    h_bits = '0;
    ssid = '0;
    ctrl = '0;
    ctrl_valid = 1'b0;
  endtask

  task automatic track_frame_byte(input logic [7:0] b, input logic last);
    int unsigned pos;
    int unsigned base;
    int unsigned len;
    int unsigned lim;
    int unsigned hdr;
    logic        crc_match;
    logic        addr_good;
    logic        found;
    summary_t    s;
    pos = nbytes;
    base = fld * 7;
    if (nbytes >= 2) begin
      run_crc = crc16_step(run_crc, held[0]);
    end
    held[0] = held[1];
    held[1] = b;
    if (pos == 13) begin
      ssid = b[4:1];
    end
    if (pos == base) begin
      ctrl = b;
      ctrl_valid = 1'b1;
    end
    if (!done_scan && fld < FieldLimit && pos == base + 6) begin
      if (fld >= 2 && fld < 10 && b[7]) begin
        h_bits[fld-2] = 1'b1;
      end
      fld++;
      ctrl_valid = 1'b0;
      if (b[0]) begin
        ext_seen = 1'b1;
        done_scan = 1'b1;
      end
      if (fld >= FieldLimit) begin
        done_scan = 1'b1;
      end
    end
    if (nbytes != 9'd511) begin
      nbytes = nbytes + 9'd1;
    end
    if (!last) begin
      return;
    end

    len = nbytes;
    crc_match = len >= 2 && run_crc == {held[1], held[0]};
    addr_good = len >= 14 && fld >= 2;
    s = '0;
    s.fcs_ok = crc_match;
    s.addr_ok = addr_good;
    s.valid_frame = len >= 14 && len <= len_limit && (!fcs_required || crc_match) &&
                    ext_seen && fld >= 2;
    if (addr_good) begin
      s.addr_fields = 4'(fld);
      s.digi_count = 4'(fld - 2);
      s.digi_used_mask = h_bits;
      lim = (fld - 2 < 8) ? fld - 2 : 8;
      found = 1'b0;
      for (int i = 0; i < lim; i++) begin
        if (!found && !h_bits[i]) begin
          found = 1'b1;
          s.has_free_digi = 1'b1;
          s.free_digi = 3'(i);
        end
      end
      hdr = fld * 7;
      if (len >= hdr + 1 && ctrl_valid) begin
        s.has_control = 1'b1;
        s.control_byte = ctrl;
        hdr += (len >= hdr + 2) ? 2 : 1;
      end
      s.hdr_bytes = 7'(hdr);
      s.sender_ssid = ssid;
    end
    expected_summaries.insert(expected_summaries.size(), s);
    clear_frame_state();
  endtask

  task automatic ship_frame();
    foreach (frame_buf[i]) begin
      pending_bytes.insert(pending_bytes.size(),
                           '{data: frame_buf[i], last: (i == frame_buf.size() - 1)});
    end
    bytes_queued += frame_buf.size();
    frame_buf = {};
  endtask

  task automatic close_frame(input bit good_fcs);
    logic [15:0] fcs;
    fcs = 16'hFFFF;
    foreach (frame_buf[i]) begin
      fcs = crc16_step(fcs, frame_buf[i]);
    end
    if (!good_fcs) begin
      fcs ^= 16'($urandom_range(16'hFFFE) + 1);
    end
    frame_buf.insert(frame_buf.size(), fcs[7:0]);
    frame_buf.insert(frame_buf.size(), fcs[15:8]);
    ship_frame();
  endtask

  task automatic queue_frame(input int unsigned nfields, input bit ended, input bit all_used,
                             input int unsigned tail_len, input bit good_fcs);
    logic [7:0] b;
    frame_buf = {};
    for (int f = 0; f < nfields; f++) begin
      repeat (6) frame_buf.insert(frame_buf.size(), 8'($urandom));
      b = 8'($urandom);
      b[0] = ended && (f == nfields - 1);
      if (all_used) begin
        b[7] = 1'b1;
      end
      frame_buf.insert(frame_buf.size(), b);
    end
    repeat (tail_len) frame_buf.insert(frame_buf.size(), 8'($urandom));
    close_frame(good_fcs);
  endtask

  task automatic raw_frame(input int unsigned len, input bit fixed, input logic [7:0] fill);
    frame_buf = {};
    repeat (len) frame_buf.insert(frame_buf.size(), fixed ? fill : 8'($urandom));
    ship_frame();
  endtask

  task automatic random_frames(input int unsigned budget);
    int unsigned start;
    int unsigned pick;
    int unsigned nf;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      pick = $urandom_range(99);
      nf = ($urandom_range(3) == 0) ? $urandom_range(5, 10) : $urandom_range(2, 4);
      if (pick < 65) begin
        queue_frame(nf, 1'b1, $urandom_range(7) == 0, $urandom_range(12),
                    $urandom_range(99) < 85);
      end else if (pick < 75) begin
        queue_frame($urandom_range(1, 10), 1'b0, 1'b0, $urandom_range(10), 1'b1);
      end else if (pick < 80) begin
        queue_frame(11, 1'b1, $urandom_range(1), 2, 1'b1);
      end else if (pick < 90) begin
        raw_frame($urandom_range(1, 20), 1'b0, 8'h00);
      end else begin
        raw_frame($urandom_range(14, 40), 1'b0, 8'h00);
      end
    end
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || in_valid || expected_summaries.size() != 0) begin
      @(posedge clk);
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_CHECK_FCS) begin
      fcs_required = val[0];
    end else if (idx == CFG_MAX_FRAME_LEN) begin
      len_limit = val;
    end
  endtask

  always @(posedge clk) begin
    frame_byte_t nxt;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        track_frame_byte(data_byte, last_byte);
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0 && !idle_now()) begin
          nxt = pending_bytes.pop_front();
          in_valid <= 1'b1;
          data_byte <= nxt.data;
          last_byte <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    summary_t got;
    summary_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{valid_frame, fcs_ok, addr_ok, addr_fields, digi_count, digi_used_mask,
                has_free_digi, free_digi, has_control, control_byte, hdr_bytes, sender_ssid};
        if (expected_summaries.size() == 0) begin
          errors++;
          $display("%0t: unexpected summary transfer, expected none actual %h", $time, got);
        end else begin
          want = expected_summaries.pop_front();
          check_field("valid_frame", want.valid_frame, got.valid_frame);
          check_field("fcs_ok", want.fcs_ok, got.fcs_ok);
          check_field("addr_ok", want.addr_ok, got.addr_ok);
          check_field("addr_fields", want.addr_fields, got.addr_fields);
          check_field("digi_count", want.digi_count, got.digi_count);
          check_field("digi_used_mask", want.digi_used_mask, got.digi_used_mask);
          check_field("has_free_digi", want.has_free_digi, got.has_free_digi);
          check_field("free_digi", want.free_digi, got.free_digi);
          check_field("has_control", want.has_control, got.has_control);
          check_field("control_byte", want.control_byte, got.control_byte);
          check_field("hdr_bytes", want.hdr_bytes, got.hdr_bytes);
          check_field("sender_ssid", want.sender_ssid, got.sender_ssid);
        end
      end
      out_ready <= (hold_left == 0) && !idle_now();
    end
  end

  // hold the receiver off once so the summary queue fills and stalls the input
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_given && bytes_taken >= HoldOffAfter) begin
      hold_left <= HoldOffCycles;
      hold_given <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("ax25_frame_header_check_unit regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    raw_frame(1, 1'b0, 8'h00);
    raw_frame(2, 1'b0, 8'h00);
    raw_frame(13, 1'b0, 8'h00);
    raw_frame(20, 1'b1, 8'hFF);
    raw_frame(20, 1'b1, 8'h00);
    queue_frame(2, 1'b1, 1'b0, 0, 1'b1);
    queue_frame(2, 1'b1, 1'b0, 1, 1'b1);
    queue_frame(3, 1'b1, 1'b0, 4, 1'b0);
    queue_frame(10, 1'b1, 1'b1, 2, 1'b1);
    queue_frame(10, 1'b0, 1'b0, 3, 1'b1);
    queue_frame(3, 1'b0, 1'b0, 0, 1'b1);
    queue_frame(2, 1'b1, 1'b0, 520, 1'b1);
    random_frames(100);
    drain();

    write_reg(CFG_CHECK_FCS, {7'($urandom), 1'b0});
    write_reg(CFG_MAX_FRAME_LEN, 8'd14);
    random_frames(150);
    drain();

    write_reg(CFG_CHECK_FCS, {7'($urandom), 1'b1});
    write_reg(CFG_MAX_FRAME_LEN, 8'd0);
    random_frames(70);
    drain();

    write_reg(CFG_CHECK_FCS, {7'($urandom), 1'b0});
    write_reg(CFG_MAX_FRAME_LEN, 8'd13);
    random_frames(70);
    drain();

    write_reg(CFG_CHECK_FCS, {7'($urandom), 1'b1});
    write_reg(CFG_MAX_FRAME_LEN, 8'($urandom_range(20, 60)));
    random_frames(180);
    drain();

    write_reg(CFG_MAX_FRAME_LEN, 8'd255);
    random_frames(130);
    drain();

    if (errors == 0) begin
      $display("ax25_frame_header_check_unit regression: pass");
    end else begin
      $display("ax25_frame_header_check_unit regression: fail");
    end
    $finish;
  end

endmodule
